// File: src/stbg_pkg.sv
// stbg_pkg: shared types, constants and the sine table builder for the tone burst generator
// used by every module under src; depends on nothing else
package stbg_pkg;

  // fixed configuration of the generator
  localparam int SampleRateHz  = 16000;
  localparam int PhaseBits     = 32;
  localparam int TableAddrBits = 10;

  localparam int QuarterLen = 1 << TableAddrBits;
  localparam int RomAddrW   = TableAddrBits + 1;
  localparam int CountW     = 21;
  localparam int AmpW       = 15;
  localparam int SampleW    = 16;
  localparam int SlotW      = 32;
  localparam int FreqW      = 13;
  localparam int MsW        = 16;

  localparam logic [AmpW-1:0] AmpReset = AmpW'(24000);
  localparam int CountPerMs = SampleRateHz / 1000;

  // phase step = freq * StepWhole + floor(freq * StepFrac / SampleRateHz)
  localparam logic [63:0] StepWhole = (64'd1 << PhaseBits) / SampleRateHz;
  localparam logic [63:0] StepFrac  = (64'd1 << PhaseBits) % SampleRateHz;
  localparam int StepWholeW = 19;
  localparam int StepFracW  = 14;
  localparam int FracProdW  = FreqW + StepFracW;

  // floor(x / SampleRateHz) as (x * RecipMul) >> RecipShift for x below 2^FracProdW
  localparam int RecipShift = FracProdW + StepFracW;
  localparam logic [63:0] RecipMul =
    ((64'd1 << RecipShift) + SampleRateHz - 1) / SampleRateHz;
  localparam int RecipW    = 28;
  localparam int RecipProdW = FracProdW + RecipW;
  localparam int QuoW      = RecipProdW - RecipShift;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [0:0] {
    OpStart = 1'b0,
    OpTick  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [FreqW-1:0]  freq_hz;
    logic [MsW-1:0]    duration_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [SlotW-1:0] left_slot;
    logic signed [SlotW-1:0] right_slot;
    logic                    tone_active;
    logic                    last_sample;
  } out_word_t;

  // per-tick control carried alongside the table read
  typedef struct packed {
    logic active;
    logic last;
    logic negate;
  } tick_info_t;

  typedef logic [SampleW-1:0] sine_tab_t [QuarterLen+1];

  // quarter-wave table, Q30 Taylor series rounded to Q1.15 and saturated
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int i = 0; i <= QuarterLen; i++) begin
      x    = (HalfPiQ30 * 64'(i)) / 64'(QuarterLen);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = ($unsigned(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[i] = v[SampleW-1:0];
    end
    return tab;
  endfunction

endpackage

// File: src/stbg_sine_rom.sv
// stbg_sine_rom: quarter-wave sine table as a synchronous ROM, one registered read port
// depends on stbg_pkg for the table builder and widths
module stbg_sine_rom (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [stbg_pkg::RomAddrW-1:0]   addr_i,
  output logic [stbg_pkg::SampleW-1:0]    data_o
);

  localparam stbg_pkg::sine_tab_t SineTab = stbg_pkg::build_sine_tab();

  logic [stbg_pkg::SampleW-1:0] data_q;

  // registered read, held while rd_en_i is low
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= SineTab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: src/stbg_phase_ctrl.sv
// stbg_phase_ctrl: phase accumulator, phase step divider and sample counter
// depends on stbg_pkg; feeds the sine ROM address and per-tick control
module stbg_phase_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            tick_i,
  input  logic [stbg_pkg::FreqW-1:0]      freq_i,
  input  logic [stbg_pkg::MsW-1:0]        ms_i,
  output logic                            step_busy_o,
  output logic [stbg_pkg::RomAddrW-1:0]   rom_addr_o,
  output stbg_pkg::tick_info_t            info_o
);

  logic [stbg_pkg::PhaseBits-1:0]     phase_q, phase_d;
  logic [stbg_pkg::PhaseBits-1:0]     step_q, step_d;
  logic [stbg_pkg::CountW-1:0]        rem_q, rem_d;
  logic                               pend_q, pend_d;
  logic [stbg_pkg::PhaseBits-1:0]     whole_q, whole_d;
  logic [stbg_pkg::FracProdW-1:0]     frac_q, frac_d;
  logic [stbg_pkg::RecipProdW-1:0]    recip_prod;
  logic [stbg_pkg::QuoW-1:0]          quo;
  logic [stbg_pkg::TableAddrBits-1:0] idx;
  logic [1:0]                         quad;
  logic                               active;

  // first half of the step: integer and fractional products of the frequency
  assign whole_d = stbg_pkg::PhaseBits'(freq_i) *
                   stbg_pkg::PhaseBits'(stbg_pkg::StepWhole[stbg_pkg::StepWholeW-1:0]);
  assign frac_d  = stbg_pkg::FracProdW'(freq_i) *
                   stbg_pkg::FracProdW'(stbg_pkg::StepFrac[stbg_pkg::StepFracW-1:0]);

  // second half: divide the fractional product by the sample rate
  assign recip_prod = stbg_pkg::RecipProdW'(frac_q) *
                      stbg_pkg::RecipProdW'(stbg_pkg::RecipMul[stbg_pkg::RecipW-1:0]);
  assign quo        = recip_prod[stbg_pkg::RecipProdW-1:stbg_pkg::RecipShift];

  // table address from the top phase bits, mirrored in odd quadrants
  assign quad   = phase_q[stbg_pkg::PhaseBits-1 -: 2];
  assign idx    = phase_q[stbg_pkg::PhaseBits-3 -: stbg_pkg::TableAddrBits];
  assign active = (rem_q != '0);

  always_comb begin
    if (quad[0]) begin
      rom_addr_o = stbg_pkg::RomAddrW'(stbg_pkg::QuarterLen) - {1'b0, idx};
    end else begin
      rom_addr_o = {1'b0, idx};
    end
  end

  assign info_o.active = active;
  assign info_o.last   = (rem_q == stbg_pkg::CountW'(1));
  assign info_o.negate = quad[1];
  assign step_busy_o   = pend_q;

  // next state of accumulator, step and count
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    rem_d   = rem_q;
    pend_d  = start_i;
    if (pend_q) begin
      step_d = whole_q + stbg_pkg::PhaseBits'(quo);
    end
    if (start_i) begin
      phase_d = '0;
      rem_d   = stbg_pkg::CountW'({5'd0, ms_i} * stbg_pkg::CountW'(stbg_pkg::CountPerMs));
    end else if (tick_i && active) begin
      phase_d = phase_q + step_q;
      rem_d   = rem_q - stbg_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
    end
  end

  // divider operands, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      whole_q <= whole_d;
      frac_q  <= frac_d;
    end
  end

endmodule

// File: src/sine_tone_burst_generator_core.sv
// sine_tone_burst_generator_core: top level of the sine tone burst generator
// depends on stbg_pkg, stbg_phase_ctrl and stbg_sine_rom
//
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    in_word_i (stbg_pkg::in_word_t)
//  out       output     out_valid_o / out_ready_i  out_word_o (stbg_pkg::out_word_t)
//  cfg       input      cfg_we_i                   cfg_wdata_i (tone amplitude)
//
// One word is accepted per cycle while in_ready_o is high. A tick is registered
// in the sine ROM stage, then amplitude-scaled into the output register.
// After a start word ready drops for one cycle while the phase step finishes
// its two-stage reciprocal multiply. Start words give no output.
// Reset: amplitude 24000, phase, step and sample count zero, pipeline empty.
// A stalled output holds its frame; one more tick can sit in the ROM stage.
module sine_tone_burst_generator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  stbg_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output stbg_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [stbg_pkg::AmpW-1:0]      cfg_wdata_i
);

  logic [stbg_pkg::AmpW-1:0]      amp_q;
  logic                           in_fire;
  logic                           start_fire;
  logic                           tick_fire;
  logic                           step_busy;
  logic [stbg_pkg::RomAddrW-1:0]  rom_addr;
  logic [stbg_pkg::SampleW-1:0]   rom_data;
  stbg_pkg::tick_info_t           info;
  logic                           s1_valid_q;
  stbg_pkg::tick_info_t           s1_info_q;
  logic                           out_valid_q;
  stbg_pkg::out_word_t            out_word_q, out_word_d;
  logic                           out_load;
  logic                           s1_free;
  logic [30:0]                    amp_prod;
  logic [stbg_pkg::SampleW-1:0]   mag;
  logic [stbg_pkg::SampleW-1:0]   sample;

  // handshake and pipeline flow
  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_free    = !s1_valid_q || out_load;
  assign in_ready_o = s1_free && !step_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign start_fire = in_fire && (in_word_i.opcode == stbg_pkg::OpStart);
  assign tick_fire  = in_fire && (in_word_i.opcode == stbg_pkg::OpTick);

  stbg_phase_ctrl u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_fire),
    .tick_i      (tick_fire),
    .freq_i      (in_word_i.freq_hz),
    .ms_i        (in_word_i.duration_ms),
    .step_busy_o (step_busy),
    .rom_addr_o  (rom_addr),
    .info_o      (info)
  );

  stbg_sine_rom u_rom (
    .clk_i   (clk_i),
    .rd_en_i (tick_fire),
    .addr_i  (rom_addr),
    .data_o  (rom_data)
  );

  // amplitude register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= stbg_pkg::AmpReset;
    end else if (cfg_we_i) begin
      amp_q <= cfg_wdata_i;
    end
  end

  // scale, sign and pack the frame
  assign amp_prod = 31'(rom_data) * 31'(amp_q);
  assign mag      = amp_prod[30:15];

  always_comb begin
    if (!s1_info_q.active) begin
      sample = '0;
    end else if (s1_info_q.negate) begin
      sample = -mag;
    end else begin
      sample = mag;
    end
    out_word_d.left_slot   = $signed({sample, 16'd0});
    out_word_d.right_slot  = $signed({sample, 16'd0});
    out_word_d.tone_active = s1_info_q.active;
    out_word_d.last_sample = s1_info_q.active && s1_info_q.last;
  end

  // rom stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_fire) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      s1_info_q <= info;
    end
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // no word may be accepted in the very next cycle after a start
  a_step_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_fire |=> !in_ready_o)
    else $error("ready high while phase step pending");

  // the rom stage is never overwritten while it still holds a frame
  a_s1_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_load) |-> !tick_fire)
    else $error("rom stage overwritten");

  // silence frames carry zero slots and no last flag
  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.tone_active) |->
      (out_word_o.left_slot == 32'sd0 && !out_word_o.last_sample))
    else $error("idle frame not silent");

  // both channels carry the same sample
  a_stereo_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.left_slot == out_word_o.right_slot))
    else $error("left and right slots differ");

endmodule

// File: dv/sine_tone_burst_generator_core_tb.sv
`timescale 1ns / 100ps
// sine_tone_burst_generator_core_tb: self-checking testbench for the tone burst generator core
// depends on stbg_pkg for the word types; predicts every output frame and checks it in order
module sine_tone_burst_generator_core_tb;

  localparam int          RATE_HZ      = 16000;
  localparam int          QUARTER      = 1024;
  localparam logic [20:0] COUNT_MAX    = 21'h1FFFFF;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int          RAND_ITEMS   = 1550;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          LONG_HOLD    = 300;
  localparam int          LIMIT        = 500000;

  typedef enum bit {RowWord, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [stbg_pkg::AmpW-1:0]      amp;
    stbg_pkg::in_word_t             word;
    bit                             typed;
    stbg_pkg::out_word_t            frame;
  } stim_row_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  stbg_pkg::in_word_t          in_word_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  stbg_pkg::out_word_t         out_word_o;
  logic                        cfg_we_i    = 1'b0;
  logic [stbg_pkg::AmpW-1:0]   cfg_wdata_i = '0;

  // predicted tone state
  logic [15:0]                 quarter_wave [0:QUARTER];
  logic [stbg_pkg::AmpW-1:0]   tone_amp;
  logic [31:0]                 tone_phase;
  logic [31:0]                 tone_step;
  logic [20:0]                 tone_left;
  stbg_pkg::out_word_t         pending_frames [$];

  stim_row_t           directed_rows [$];
  int                  errors     = 0;
  int                  cycle_count = 0;
  int                  n_items    = 0;
  int                  n_ticks    = 0;
  int                  n_starts   = 0;
  int                  n_frames   = 0;
  int                  n_last     = 0;
  int                  n_amp_sets = 0;
  bit                  quiet      = 1'b0;
  bit                  hold_req   = 1'b0;
  int                  stall_left = 0;

  sine_tone_burst_generator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // quarter-wave sine, Q30 Taylor series rounded to Q1.15
  task automatic fill_quarter_wave();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int i = 0; i <= QUARTER; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) / longint'(QUARTER);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + 64'd16384) >> 15;
      quarter_wave[i] = (v > 64'd32767) ? 16'd32767 : v[15:0];
    end
  endtask

  // slot for one phase value: quadrant fold, table read, amplitude scale
  function automatic logic [31:0] tone_slot(logic [31:0] ph);
    logic [1:0]  quad;
    logic [10:0] idx;
    logic [31:0] mag;
    quad = ph[31:30];
    idx  = {1'b0, ph[29:20]};
    if (quad[0]) idx = 11'(QUARTER) - idx;
    mag = (32'(quarter_wave[idx]) * 32'(tone_amp)) >> 15;
    if (quad[1]) mag = 32'd0 - mag;
    return {mag[15:0], 16'h0000};
  endfunction

  // advance the predicted state by one word; returns 1 when a frame is due
  function automatic bit predict_word(input stbg_pkg::in_word_t w,
                                      output stbg_pkg::out_word_t f);
    logic [63:0] cnt;
    logic [31:0] slot;
    f = '0;
    if (w.opcode == stbg_pkg::OpStart) begin
      cnt        = (64'(RATE_HZ) * 64'(w.duration_ms)) / 64'd1000;
      tone_phase = '0;
      tone_step  = 32'((64'(w.freq_hz) << 32) / 64'(RATE_HZ));
      tone_left  = (cnt > 64'(COUNT_MAX)) ? COUNT_MAX : cnt[20:0];
      return 1'b0;
    end
    if (tone_left != '0) begin
      slot          = tone_slot(tone_phase);
      tone_phase    = tone_phase + tone_step;
      tone_left     = tone_left - 21'd1;
      f.left_slot   = slot;
      f.right_slot  = slot;
      f.tone_active = 1'b1;
      f.last_sample = (tone_left == '0);
    end
    return 1'b1;
  endfunction

  function automatic stbg_pkg::out_word_t frame_of(logic [31:0] slot, bit act, bit last);
    stbg_pkg::out_word_t f;
    f.left_slot   = slot;
    f.right_slot  = slot;
    f.tone_active = act;
    f.last_sample = last;
    return f;
  endfunction

  function automatic stbg_pkg::in_word_t word_of(stbg_pkg::opcode_e op, int f, int ms);
    stbg_pkg::in_word_t w;
    w.opcode      = op;
    w.freq_hz     = stbg_pkg::FreqW'(f);
    w.duration_ms = stbg_pkg::MsW'(ms);
    return w;
  endfunction

  function automatic stim_row_t word_row(stbg_pkg::opcode_e op, int f, int ms);
    stim_row_t r;
    r.kind  = RowWord;
    r.amp   = '0;
    r.word  = word_of(op, f, ms);
    r.typed = 1'b0;
    r.frame = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(stbg_pkg::out_word_t fr);
    stim_row_t r;
    r       = word_row(stbg_pkg::OpTick, 0, 0);
    r.typed = 1'b1;
    r.frame = fr;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(int a);
    stim_row_t r;
    r      = word_row(stbg_pkg::OpTick, 0, 0);
    r.kind = RowCfg;
    r.amp  = stbg_pkg::AmpW'(a);
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one word until taken, then record its expected frame
  task automatic send_word(input stbg_pkg::in_word_t w, input bit typed,
                           input stbg_pkg::out_word_t typed_frame);
    stbg_pkg::out_word_t f;
    int                  g;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (w.opcode == stbg_pkg::OpStart) n_starts++;
    else n_ticks++;
    if (predict_word(w, f)) pending_frames.push_back(typed ? typed_frame : f);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // wait until every frame is out and a start could have settled
  task automatic idle_wait();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_amplitude(input logic [stbg_pkg::AmpW-1:0] a);
    idle_wait();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tone_amp    = a;
    n_amp_sets++;
  endtask

  function automatic int pick_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 10) return 8000;
    if (r < 15) return 8191;
    if (r < 25) return $urandom & 32'h1FFF;
    return $urandom_range(1, 8000);
  endfunction

  // compare one frame with the oldest expectation
  task automatic check_frame(input stbg_pkg::out_word_t got);
    stbg_pkg::out_word_t want;
    if (pending_frames.size() == 0) begin
      $display("%0t: frame with none expected, expected none, got %h", $time, got);
      errors++;
    end else begin
      want = pending_frames.pop_front();
      n_frames++;
      if (got.last_sample) n_last++;
      if (got.left_slot !== want.left_slot) begin
        $display("%0t: left_slot mismatch, expected %h, got %h",
                 $time, want.left_slot, got.left_slot);
        errors++;
      end
      if (got.right_slot !== want.right_slot) begin
        $display("%0t: right_slot mismatch, expected %h, got %h",
                 $time, want.right_slot, got.right_slot);
        errors++;
      end
      if (got.tone_active !== want.tone_active) begin
        $display("%0t: tone_active mismatch, expected %b, got %b",
                 $time, want.tone_active, got.tone_active);
        errors++;
      end
      if (got.last_sample !== want.last_sample) begin
        $display("%0t: last_sample mismatch, expected %b, got %b",
                 $time, want.last_sample, got.last_sample);
        errors++;
      end
    end
  endtask

  // output side: check accepted frames, stall at random, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_frame(out_word_o);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        stall_left  = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else begin
        stall_left  = gap_len();
        out_ready_i <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    int        burst;
    int        ms;
    int        ticks;
    int        r;
    int        f;
    fill_quarter_wave();
    tone_amp   = stbg_pkg::AmpReset;
    tone_phase = '0;
    tone_step  = '0;
    tone_left  = '0;

    // directed words: reset amplitude, quarter-rate tone at full scale, empty burst,
    // widest fields, restart mid-burst, zero and minimal amplitude
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b0, 1'b0)));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 4000, 1));
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b1, 1'b0)));
    directed_rows.push_back(typed_row(frame_of(32'h5DBF_0000, 1'b1, 1'b0)));
    directed_rows.push_back(cfg_row(32767));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 4000, 1));
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b1, 1'b0)));
    directed_rows.push_back(typed_row(frame_of(32'h7FFE_0000, 1'b1, 1'b0)));
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b1, 1'b0)));
    directed_rows.push_back(typed_row(frame_of(32'h8002_0000, 1'b1, 1'b0)));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 8191, 65535));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 0, 0));
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b0, 1'b0)));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 8191, 65535));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 0, 0));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 0, 0));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 8000, 1));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 0, 0));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 0, 0));
    directed_rows.push_back(cfg_row(0));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 4000, 1));
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b1, 1'b0)));
    directed_rows.push_back(typed_row(frame_of(32'h0000_0000, 1'b1, 1'b0)));
    directed_rows.push_back(cfg_row(1));
    directed_rows.push_back(word_row(stbg_pkg::OpStart, 4095, 3));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 0, 0));
    directed_rows.push_back(word_row(stbg_pkg::OpTick, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == RowCfg) write_amplitude(row.amp);
      else send_word(row.word, row.typed, row.frame);
    end

    // random bursts: a start then roughly its tick count, with some noise
    burst = 0;
    while (n_items < RAND_ITEMS + directed_rows.size()) begin
      if (burst % 8 == 0) begin
        case ((burst / 8) % 5)
          0: write_amplitude(stbg_pkg::AmpW'(32767));
          1: write_amplitude(stbg_pkg::AmpW'(0));
          2: write_amplitude(stbg_pkg::AmpW'(1));
          3: write_amplitude(stbg_pkg::AmpReset);
          default: write_amplitude(stbg_pkg::AmpW'($urandom_range(0, 32767)));
        endcase
      end
      quiet = ($urandom_range(0, 99) < 20);
      r = $urandom_range(0, 99);
      if (burst == 12) begin
        // long output hold while ticks keep coming
        quiet    = 1'b1;
        hold_req = 1'b1;
        ms       = 20;
        ticks    = 80;
      end else if (r < 8) begin
        // any duration bits, cut short
        ms    = $urandom & 32'hFFFF;
        ticks = $urandom_range(0, 10);
      end else begin
        ms    = (r < 85) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        ticks = 16 * ms + $urandom_range(0, 4);
        if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, 16 * ms);
      end
      f = pick_freq();
      if ($urandom_range(0, 99) < 5) begin
        // back-to-back starts
        send_word(word_of(stbg_pkg::OpStart, pick_freq(), $urandom & 32'hFFFF), 1'b0, '0);
      end
      send_word(word_of(stbg_pkg::OpStart, f, ms), 1'b0, '0);
      for (int t = 0; t < ticks; t++) begin
        // ticks carry random unused fields
        send_word(word_of(stbg_pkg::OpTick, $urandom & 32'h1FFF, $urandom & 32'hFFFF),
                  1'b0, '0);
      end
      burst++;
    end

    quiet = 1'b0;
    idle_wait();
    if (pending_frames.size() != 0) begin
      $display("%0t: %0d frames never arrived", $time, pending_frames.size());
      errors++;
    end
    $display("covered %0d starts and %0d ticks over %0d bursts, %0d amplitude settings",
             n_starts, n_ticks, burst, n_amp_sets);
    $display("checked %0d frames, %0d bursts ran to their last sample, %0d errors",
             n_frames, n_last, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sine_tone_burst_generator_core.f
src/stbg_pkg.sv
src/stbg_sine_rom.sv
src/stbg_phase_ctrl.sv
src/sine_tone_burst_generator_core.sv
dv/sine_tone_burst_generator_core_tb.sv
